[rtl/two_level_interrupt_priority_check_core_defines.svh]
// ----------------------------------------------------------------------------
// Interrupt priority check assertion macros
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_INTERRUPT_PRIORITY_CHECK_CORE_DEFINES_SVH
`define TWO_LEVEL_INTERRUPT_PRIORITY_CHECK_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Clocked assertion, disabled while reset is asserted
`define TLIPC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Clocked assertion that also holds during reset
`define TLIPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TLIPC_ASSERT(lbl, clk, rstn, prop, msg)
`define TLIPC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[rtl/tlipc_pkg.sv]
// ----------------------------------------------------------------------------
// Interrupt priority check package
// Shared types, register bit positions and vector constants.
// ----------------------------------------------------------------------------
package tlipc_pkg;

    // Internal level code, ordered so a plain compare gives precedence
    typedef enum logic [1:0] {
        LVL_NONE = 2'd0,
        LVL_LOW  = 2'd1,
        LVL_HIGH = 2'd2
    } lvl_t;

    // Signed two-bit level as seen on the result channel
    localparam logic [1:0] OUT_LVL_NONE = 2'b11;
    localparam logic [1:0] OUT_LVL_LOW  = 2'b00;
    localparam logic [1:0] OUT_LVL_HIGH = 2'b01;

    // Source codes in scan order
    localparam logic [1:0] SRC_TIMER0 = 2'd0;
    localparam logic [1:0] SRC_TIMER1 = 2'd1;
    localparam logic [1:0] SRC_SERIAL = 2'd2;
    localparam logic [1:0] SRC_TIMER2 = 2'd3;

    // IE / IP bit positions
    localparam int IE_EA_BIT  = 7;
    localparam int EN_T0_BIT  = 1;
    localparam int EN_T1_BIT  = 3;
    localparam int EN_SER_BIT = 4;
    localparam int EN_T2_BIT  = 5;

    // Flag bit positions
    localparam int TCON_TF0_BIT  = 5;
    localparam int TCON_TF1_BIT  = 7;
    localparam int T2CON_TF2_BIT = 7;

    // Handler addresses
    localparam logic [5:0] VEC_TIMER0 = 6'h0B;
    localparam logic [5:0] VEC_TIMER1 = 6'h1B;
    localparam logic [5:0] VEC_SERIAL = 6'h23;
    localparam logic [5:0] VEC_TIMER2 = 6'h2B;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 40;

    typedef struct packed {
        logic [7:0]  enable_reg;
        logic [7:0]  priority_reg;
        logic [7:0]  timer_control_reg;
        logic [7:0]  serial_control_reg;
        logic [7:0]  timer2_control_reg;
        logic [15:0] current_pc;
        logic        handler_return;
    } in_item_t;

    typedef struct packed {
        logic        taken;
        logic [5:0]  vector;
        logic [1:0]  source;
        logic [1:0]  new_level;
        logic [15:0] push_pc;
        logic [7:0]  timer_control_out;
    } out_item_t;

    function automatic logic [1:0] level_code(input lvl_t lv);
        logic [1:0] code;
        unique case (lv)
            LVL_HIGH: code = OUT_LVL_HIGH;
            LVL_LOW:  code = OUT_LVL_LOW;
            default:  code = OUT_LVL_NONE;
        endcase
        return code;
    endfunction

endpackage

[rtl/tlipc_scan.sv]
// ----------------------------------------------------------------------------
// Interrupt priority scan
// Two-level, fixed-order request selection for one tick.
// ----------------------------------------------------------------------------
module tlipc_scan
    import tlipc_pkg::*;
(
    input  in_item_t  item,
    input  lvl_t      level_cur,
    output lvl_t      level_next,
    output out_item_t result
);

    logic [3:0] en_vec;
    logic [3:0] hi_vec;
    logic [3:0] flag_vec;
    logic [3:0] hi_req;
    logic [3:0] lo_req;
    logic [3:0] pick;
    lvl_t       level_base;
    logic       take_hi;
    logic       take_lo;
    logic       taken;
    logic [1:0] src;
    logic [5:0] vec;
    logic [7:0] tcon;

    assign en_vec = {item.enable_reg[EN_T2_BIT], item.enable_reg[EN_SER_BIT],
                     item.enable_reg[EN_T1_BIT], item.enable_reg[EN_T0_BIT]};
    assign hi_vec = {item.priority_reg[EN_T2_BIT], item.priority_reg[EN_SER_BIT],
                     item.priority_reg[EN_T1_BIT], item.priority_reg[EN_T0_BIT]};
    assign flag_vec = {item.timer2_control_reg[T2CON_TF2_BIT],
                       |item.serial_control_reg[1:0],
                       item.timer_control_reg[TCON_TF1_BIT],
                       item.timer_control_reg[TCON_TF0_BIT]};

    // A return drops the level before the scan sees it
    assign level_base = item.handler_return ? LVL_NONE : level_cur;

    assign hi_req  = en_vec & hi_vec & flag_vec;
    assign lo_req  = en_vec & ~hi_vec & flag_vec;
    assign take_hi = item.enable_reg[IE_EA_BIT] && (level_base != LVL_HIGH) && (|hi_req);
    assign take_lo = item.enable_reg[IE_EA_BIT] && (level_base == LVL_NONE) && !take_hi
                     && (|lo_req);
    assign taken   = take_hi || take_lo;
    assign pick    = take_hi ? hi_req : lo_req;

    always_comb begin
        priority if (pick[0]) begin
            src = SRC_TIMER0;
        end else if (pick[1]) begin
            src = SRC_TIMER1;
        end else if (pick[2]) begin
            src = SRC_SERIAL;
        end else begin
            src = SRC_TIMER2;
        end
    end

    always_comb begin
        tcon = item.timer_control_reg;
        unique case (src)
            SRC_TIMER0: begin
                vec = VEC_TIMER0;
                if (taken) tcon[TCON_TF0_BIT] = 1'b0;
            end
            SRC_TIMER1: begin
                vec = VEC_TIMER1;
                if (taken) tcon[TCON_TF1_BIT] = 1'b0;
            end
            SRC_SERIAL: vec = VEC_SERIAL;
            default:    vec = VEC_TIMER2;
        endcase
    end

    always_comb begin
        if (take_hi) begin
            level_next = LVL_HIGH;
        end else if (take_lo) begin
            level_next = LVL_LOW;
        end else begin
            level_next = level_base;
        end
    end

    assign result.taken             = taken;
    assign result.vector            = taken ? vec : 6'd0;
    assign result.source            = taken ? src : SRC_TIMER0;
    assign result.new_level         = level_code(level_next);
    assign result.push_pc           = taken ? item.current_pc : 16'd0;
    assign result.timer_control_out = tcon;

endmodule

[rtl/two_level_interrupt_priority_check_core.sv]
// ----------------------------------------------------------------------------
// Two-level interrupt priority check core
// 8051-style interrupt arbitration, one machine-cycle tick per request.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel carries one request per machine-cycle tick: the IE, IP, TCON,
//   SCON and T2CON snapshots, the PC and a handler-return strobe.
//   m_* channel returns exactly one result per request: taken flag, vector,
//   source, active level after the tick, PC to push and the updated TCON.
// Path: a request passes the input register, then the result register; m_tvalid
//   rises when it reaches the result register. Throughput: one request per
//   clock while m_tready stays high; the active level is updated when
//   a request moves from the input register to the result register, so
//   back-to-back requests see each other's level.
// Reset: aresetn low empties both registers and sets the active level to
//   none.
// Stall: while m_tready is low the result holds; an empty input register
//   still fills, so at most one more request is taken before s_tready drops.
// ----------------------------------------------------------------------------
`include "two_level_interrupt_priority_check_core_defines.svh"

module two_level_interrupt_priority_check_core
    import tlipc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // tdata: enable_reg[7:0], priority_reg[15:8], timer_control_reg[23:16],
    //        serial_control_reg[31:24], timer2_control_reg[39:32],
    //        current_pc[55:40], handler_return[56], zero fill [63:57]
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // tdata: taken[0], vector[6:1], source[8:7], new_level[10:9],
    //        push_pc[26:11], timer_control_out[34:27], zero fill [39:35]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    in_item_t  in_item_reg;
    in_item_t  in_item_next;
    logic      in_valid_reg;
    out_item_t out_item_reg;
    out_item_t scan_result;
    logic      out_valid_reg;
    lvl_t      level_reg;
    lvl_t      level_next;
    logic      advance;
    logic      s_accept;

    // Unpack the request
    assign in_item_next.enable_reg         = s_tdata[7:0];
    assign in_item_next.priority_reg       = s_tdata[15:8];
    assign in_item_next.timer_control_reg  = s_tdata[23:16];
    assign in_item_next.serial_control_reg = s_tdata[31:24];
    assign in_item_next.timer2_control_reg = s_tdata[39:32];
    assign in_item_next.current_pc         = s_tdata[55:40];
    assign in_item_next.handler_return     = s_tdata[56];

    // Move a held request forward when the result slot is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    tlipc_scan u_scan (
        .item       (in_item_reg),
        .level_cur  (level_reg),
        .level_next (level_next),
        .result     (scan_result)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg <= in_item_next;
        end
    end

    // Active level and result register advance together
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg     <= LVL_NONE;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                level_reg <= level_next;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_item_reg <= scan_result;
        end
    end

    // Pack the result
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0,
                       out_item_reg.timer_control_out,
                       out_item_reg.push_pc,
                       out_item_reg.new_level,
                       out_item_reg.source,
                       out_item_reg.vector,
                       out_item_reg.taken};

    // A taken result always reports a live level
    `TLIPC_ASSERT(a_taken_has_level, aclk, aresetn, (out_valid_reg && out_item_reg.taken) |-> (out_item_reg.new_level != OUT_LVL_NONE), "taken result with level none")
    // No vector or PC is shown without a taken interrupt
    `TLIPC_ASSERT(a_idle_fields_zero, aclk, aresetn, (out_valid_reg && !out_item_reg.taken) |-> (out_item_reg.vector == 6'd0 && out_item_reg.push_pc == 16'd0), "idle result carries vector or pc")
    // The active level moves only when a request is scanned
    `TLIPC_ASSERT(a_level_moves_on_advance, aclk, aresetn, !$stable(level_reg) |-> $past(advance), "active level changed without a request")
    // A scanned request always fills the result register
    `TLIPC_ASSERT(a_advance_fills_out, aclk, aresetn, advance |=> out_valid_reg, "scanned request lost")

endmodule
